### hw/rtl/pedal_plausibility_monitor_core_defines.svh
// Assertion helpers for the pedal monitor core.
// Each macro expects clk and arst_n in scope.
`ifndef PEDAL_PLAUSIBILITY_MONITOR_CORE_DEFINES_SVH
`define PEDAL_PLAUSIBILITY_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define PPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ppm_pkg.sv
package ppm_pkg;

	// build defaults
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIMER_BITS_DEF  = 16;

	// raw word alignment
	localparam int ADC_SHIFT = 3;

	// register indexes
	localparam logic [2:0] REG_PEDAL_A_RANGE     = 3'd0;
	localparam logic [2:0] REG_PEDAL_B_RANGE     = 3'd1;
	localparam logic [2:0] REG_FRONT_BRAKE_RANGE = 3'd2;
	localparam logic [2:0] REG_REAR_BRAKE_RANGE  = 3'd3;
	localparam logic [2:0] REG_PRESSED_TH        = 3'd4;
	localparam logic [2:0] REG_SHORT_TH          = 3'd5;
	localparam logic [2:0] REG_OPEN_TH           = 3'd6;
	localparam logic [2:0] REG_TIMEOUT           = 3'd7;

	// register reset values
	localparam logic [31:0] RANGE_RESET      = 32'h07FF_0000;
	localparam logic [11:0] PRESSED_TH_RESET = 12'd200;
	localparam logic [11:0] SHORT_TH_RESET   = 12'd50;
	localparam logic [11:0] OPEN_TH_RESET    = 12'd2000;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd100;

	// request kinds
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// timer phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_EXP  = 2'd2;

	// fault flag bits
	localparam int FLT_DISAGREE = 0;
	localparam int FLT_BT       = 1;
	localparam int FLT_LINE     = 2;
	localparam int FLT_RANGE    = 3;

	typedef struct packed {
		logic        req_type;
		logic [15:0] pedal_a_word;
		logic [15:0] pedal_b_word;
		logic [15:0] front_brake_word;
		logic [15:0] rear_brake_word;
		logic        brake_line_ok;
	} in_item_t;

	typedef struct packed {
		logic [14:0] pedal_a_scaled;
		logic [14:0] pedal_b_scaled;
		logic [14:0] brake_front_scaled;
		logic [14:0] brake_rear_scaled;
		logic        brake_is_pressed;
		logic        any_fault;
		logic        disagree_fault;
		logic        brake_throttle_fault;
		logic        brake_line_fault;
		logic        pedal_range_fault;
	} out_item_t;

endpackage

### hw/rtl/pedal_plausibility_monitor_core.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_item_t
// out       output     out_valid/out_stall out_item_t
// cfg       input      cfg_we             cfg_addr, cfg_data
//
// A tick item goes straight to the final step, which registers its result; a
// sample item runs its four channels in turn through one shared restoring
// divider, then operand setup, products on one shared multiplier, the difference,
// the compares and the output load. Reset (arst_n low) clears all flags, timers,
// scaled values and the output register and loads the configuration reset values.
// The result sits in an output register; a stalled result holds the block
// in its final step until it is taken.
`include "pedal_plausibility_monitor_core_defines.svh"

module pedal_plausibility_monitor_core
	import ppm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam int S   = SAMPLE_BITS;
	localparam int DW  = S + 2;
	localparam int PW  = 2 * DW;
	localparam int XW  = PW + 1;
	localparam int CW  = XW + 7;
	localparam int EW  = ((S > 12) ? S : 12) + 1;
	localparam int TB  = TIMER_BITS;
	localparam int TCW = (TB > 16) ? TB : 16;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SETUP = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_PREP  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_DIFF  = 4'd5;
	localparam logic [3:0] ST_CMP   = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;

	localparam logic [3:0] DIV_LAST = 4'd14;

	// configuration
	logic [31:0] rng_q [4];
	logic [11:0] press_th_q, short_th_q, open_th_q;
	logic [15:0] timeout_q;

	// control and state
	logic [3:0]    state_q;
	logic [1:0]    ch_q;
	logic [1:0]    mstep_q;
	logic [3:0]    cnt_q;
	logic [S-1:0]  raw_q [4];
	logic          line_ok_q;
	logic [14:0]   scaled_q [4];
	logic          pressed_q;
	logic [3:0]    flt_q;
	logic [1:0]    ph_q [3];
	logic [TB-1:0] tcnt_q [3];
	logic          out_valid_q;
	out_item_t     out_data_q;

	// divider datapath
	logic [S-1:0]  span_q;
	logic          zero_q;
	logic [14:0]   nlo_q;
	logic [S:0]    rem_q;
	logic [14:0]   quo_q;

	// multiply datapath
	logic signed [DW-1:0] na_q, nb_q, da_q, db_q;
	logic signed [PW-1:0] p1_q, p2_q, p3_q;
	logic [XW-1:0]        absx_q;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	// result load in the final step
	logic fin_go;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// sample extraction
	function automatic logic [S-1:0] get_raw(input logic [15:0] w);
		logic [15:0] sh;
		sh = w >> ADC_SHIFT;
		return sh[S-1:0];
	endfunction

	// per-channel setup for the divider
	logic signed [S-1:0] lo_s, hi_s, r_s, c_s;
	logic signed [S:0]   span_s, d_s;
	logic                span_pos;
	logic [S+14:0]       n_w;
	always_comb begin
		lo_s = rng_q[ch_q][S-1:0];
		hi_s = rng_q[ch_q][16+S-1:16];
		r_s  = raw_q[ch_q];
		span_s = $signed({hi_s[S-1], hi_s}) - $signed({lo_s[S-1], lo_s});
		span_pos = !span_s[S] && (span_s != '0);
		if (r_s < lo_s)
			c_s = lo_s;
		else if (r_s > hi_s)
			c_s = hi_s;
		else
			c_s = r_s;
		if (ch_q == 2'd1)
			d_s = $signed({hi_s[S-1], hi_s}) - $signed({c_s[S-1], c_s});
		else
			d_s = $signed({c_s[S-1], c_s}) - $signed({lo_s[S-1], lo_s});
		n_w = {d_s[S-1:0], 15'd0} - {15'd0, d_s[S-1:0]};
	end

	// one restoring divider step
	logic [S:0] rem_sh, rem_n;
	logic       ge;
	always_comb begin
		rem_sh = {rem_q[S-1:0], nlo_q[cnt_q]};
		ge = rem_sh >= {1'b0, span_q};
		rem_n = ge ? (rem_sh - {1'b0, span_q}) : rem_sh;
	end

	// percent numerators and denominators for both pedals
	logic signed [S-1:0] lo0, hi0, lo1, hi1;
	logic signed [S:0]   sp0, sp1, nae, nbe;
	logic                pos0, pos1;
	always_comb begin
		lo0 = rng_q[0][S-1:0];
		hi0 = rng_q[0][16+S-1:16];
		lo1 = rng_q[1][S-1:0];
		hi1 = rng_q[1][16+S-1:16];
		sp0 = $signed({hi0[S-1], hi0}) - $signed({lo0[S-1], lo0});
		sp1 = $signed({hi1[S-1], hi1}) - $signed({lo1[S-1], lo1});
		pos0 = !sp0[S] && (sp0 != '0);
		pos1 = !sp1[S] && (sp1 != '0);
		nae = $signed({raw_q[0][S-1], raw_q[0]}) - $signed({lo0[S-1], lo0});
		nbe = $signed({hi1[S-1], hi1}) - $signed({raw_q[1][S-1], raw_q[1]});
	end

	// shared multiplier
	logic signed [DW-1:0] ma, mb;
	logic signed [PW-1:0] mp;
	always_comb begin
		case (mstep_q)
			2'd0: begin
				ma = na_q;
				mb = db_q;
			end
			2'd1: begin
				ma = nb_q;
				mb = da_q;
			end
			default: begin
				ma = da_q;
				mb = db_q;
			end
		endcase
		mp = ma * mb;
	end

	// disagreement difference
	logic signed [XW-1:0] x_w;
	always_comb begin
		x_w = $signed({p1_q[PW-1], p1_q}) - $signed({p2_q[PW-1], p2_q});
	end

	// final checks
	logic [CW-1:0]   lhs, rhs;
	logic [DW-1:0]   abs_na;
	logic [DW+4:0]   na4, na20, da_e;
	logic            dis_bad, bt_set, bt_clr, pressed_n, rng_ok;
	logic signed [EW-1:0] r0e, r1e, r2e, pte, ste, ote;
	always_comb begin
		lhs = ({{(CW-XW){1'b0}}, absx_q} << 6) + ({{(CW-XW){1'b0}}, absx_q} << 5)
			+ ({{(CW-XW){1'b0}}, absx_q} << 2);
		rhs = ({{(CW-PW){1'b0}}, p3_q} << 3) + ({{(CW-PW){1'b0}}, p3_q} << 1)
			+ {{(CW-PW){1'b0}}, p3_q};
		dis_bad = lhs >= rhs;
		abs_na = na_q[DW-1] ? DW'(-na_q) : DW'(na_q);
		na4  = {5'd0, abs_na} << 2;
		na20 = ({5'd0, abs_na} << 4) + ({5'd0, abs_na} << 2);
		da_e = {5'd0, da_q};
		r0e = {{(EW-S){raw_q[0][S-1]}}, raw_q[0]};
		r1e = {{(EW-S){raw_q[1][S-1]}}, raw_q[1]};
		r2e = {{(EW-S){raw_q[2][S-1]}}, raw_q[2]};
		pte = {{(EW-12){press_th_q[11]}}, press_th_q};
		ste = {{(EW-12){short_th_q[11]}}, short_th_q};
		ote = {{(EW-12){open_th_q[11]}}, open_th_q};
		pressed_n = r2e >= pte;
		bt_set = pressed_n && (na4 > da_e);
		bt_clr = na20 < da_e;
		rng_ok = (r0e >= ste) && (r0e <= ote) && (r1e >= ste) && (r1e <= ote);
	end

	// persistence conditions per timer
	logic [2:0] bad_w;
	assign bad_w = {!rng_ok, !line_ok_q, dis_bad};

	// timer tick next values
	logic [1:0]    ph_t [3];
	logic [TB-1:0] tcnt_t [3];
	logic [3:0]    flt_t;
	always_comb begin
		flt_t = flt_q;
		for (int i = 0; i < 3; i++) begin
			ph_t[i] = ph_q[i];
			tcnt_t[i] = tcnt_q[i];
			if (ph_q[i] == PH_RUN) begin
				if (tcnt_q[i] != {TB{1'b1}})
					tcnt_t[i] = tcnt_q[i] + 1'b1;
				if (TCW'(tcnt_t[i]) >= TCW'(timeout_q)) begin
					ph_t[i] = PH_EXP;
					case (i)
						0: flt_t[FLT_DISAGREE] = 1'b1;
						1: flt_t[FLT_LINE] = 1'b1;
						default: flt_t[FLT_RANGE] = 1'b1;
					endcase
				end
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				rng_q[i] <= RANGE_RESET;
			press_th_q <= PRESSED_TH_RESET;
			short_th_q <= SHORT_TH_RESET;
			open_th_q  <= OPEN_TH_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PEDAL_A_RANGE:     rng_q[0] <= cfg_data;
				REG_PEDAL_B_RANGE:     rng_q[1] <= cfg_data;
				REG_FRONT_BRAKE_RANGE: rng_q[2] <= cfg_data;
				REG_REAR_BRAKE_RANGE:  rng_q[3] <= cfg_data;
				REG_PRESSED_TH:        press_th_q <= cfg_data[11:0];
				REG_SHORT_TH:          short_th_q <= cfg_data[11:0];
				REG_OPEN_TH:           open_th_q <= cfg_data[11:0];
				REG_TIMEOUT:           timeout_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q[0] <= get_raw(in_data.pedal_a_word);
			raw_q[1] <= get_raw(in_data.pedal_b_word);
			raw_q[2] <= get_raw(in_data.front_brake_word);
			raw_q[3] <= get_raw(in_data.rear_brake_word);
			line_ok_q <= in_data.brake_line_ok;
		end
		case (state_q)
			ST_SETUP: begin
				span_q <= span_s[S-1:0];
				zero_q <= !span_pos;
				nlo_q  <= n_w[14:0];
				rem_q  <= {1'b0, n_w[S+14:15]};
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= {quo_q[13:0], ge};
			end
			ST_PREP: begin
				na_q <= pos0 ? DW'(nae) : '0;
				da_q <= pos0 ? DW'(sp0) : DW'(1);
				nb_q <= pos1 ? DW'(nbe) : '0;
				db_q <= pos1 ? DW'(sp1) : DW'(1);
			end
			ST_MUL: begin
				case (mstep_q)
					2'd0: p1_q <= mp;
					2'd1: p2_q <= mp;
					default: p3_q <= mp;
				endcase
			end
			ST_DIFF: begin
				absx_q <= x_w[XW-1] ? XW'(-x_w) : XW'(x_w);
			end
			default: ;
		endcase
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q <= '0;
			mstep_q <= '0;
			cnt_q <= '0;
			pressed_q <= 1'b0;
			flt_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			for (int i = 0; i < 4; i++)
				scaled_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				ph_q[i] <= PH_IDLE;
				tcnt_q[i] <= '0;
			end
		end else begin
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.req_type == REQ_TICK) begin
							for (int i = 0; i < 3; i++) begin
								ph_q[i] <= ph_t[i];
								tcnt_q[i] <= tcnt_t[i];
							end
							flt_q <= flt_t;
							state_q <= ST_FIN;
						end else begin
							ch_q <= '0;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					cnt_q <= DIV_LAST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						scaled_q[ch_q] <= zero_q ? 15'd0 : {quo_q[13:0], ge};
						if (ch_q == 2'd3) begin
							state_q <= ST_PREP;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= ST_SETUP;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_PREP: begin
					mstep_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mstep_q == 2'd2)
						state_q <= ST_DIFF;
					else
						mstep_q <= mstep_q + 1'b1;
				end
				ST_DIFF: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					pressed_q <= pressed_n;
					if (bt_clr)
						flt_q[FLT_BT] <= 1'b0;
					else if (bt_set)
						flt_q[FLT_BT] <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (bad_w[i] && ph_q[i] == PH_IDLE) begin
							ph_q[i] <= PH_RUN;
							tcnt_q[i] <= '0;
						end else if (!bad_w[i] && ph_q[i] == PH_RUN) begin
							ph_q[i] <= PH_IDLE;
							tcnt_q[i] <= '0;
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_data_q.pedal_a_scaled <= scaled_q[0];
						out_data_q.pedal_b_scaled <= scaled_q[1];
						out_data_q.brake_front_scaled <= scaled_q[2];
						out_data_q.brake_rear_scaled <= scaled_q[3];
						out_data_q.brake_is_pressed <= pressed_q;
						out_data_q.any_fault <= |flt_q;
						out_data_q.disagree_fault <= flt_q[FLT_DISAGREE];
						out_data_q.brake_throttle_fault <= flt_q[FLT_BT];
						out_data_q.brake_line_fault <= flt_q[FLT_LINE];
						out_data_q.pedal_range_fault <= flt_q[FLT_RANGE];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// checks
	`PPM_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "accept did not start work")
	`PPM_ASSERT_NOW(a_div_count, state_q == ST_DIV, cnt_q <= DIV_LAST, "divider count overrun")
	`PPM_ASSERT_NEXT(a_disagree_sticky, flt_q[FLT_DISAGREE], flt_q[FLT_DISAGREE], "fault cleared")
	`PPM_ASSERT_NEXT(a_timer_expired, ph_q[0] == PH_EXP, ph_q[0] == PH_EXP, "timer left expiry")
	`PPM_ASSERT_NOW(a_fin_rem, state_q == ST_DIV, rem_q < (S+1)'(span_q) || zero_q, "bad remainder")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ppm_pkg::*;

	localparam int  NUM_DIRECTED = 20;
	localparam int  NUM_RANDOM   = 1030;
	localparam int  DRAIN_CYCLES = 100;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int  CNT_MAX      = 65535;
	localparam int  IN_W         = $bits(in_item_t);

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;

	pedal_plausibility_monitor_core dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// monitor state mirror
	logic [31:0]        win_cfg [4];
	logic signed [11:0] pressed_th, short_th, open_th;
	logic [15:0]        timeout_ticks;
	logic [14:0]        scaled_q [4];
	logic               pressed_q;
	logic [1:0]         tmr_phase [3];
	int                 tmr_count [3];
	logic [3:0]         faults;

	out_item_t exp_q [$];
	int        fails = 0;
	int        idle_mode = 2;
	longint    cycles = 0;

	function automatic longint win_lo(int ch);
		return longint'($signed(win_cfg[ch][11:0]));
	endfunction

	function automatic longint win_hi(int ch);
		return longint'($signed(win_cfg[ch][27:16]));
	endfunction

	function automatic longint labs(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [14:0] scale_ch(longint raw, int ch);
		longint lo, hi, span, c, d;
		lo = win_lo(ch);
		hi = win_hi(ch);
		span = hi - lo;
		if (span <= 0) return '0;
		c = raw;
		if (c < lo) c = lo;
		else if (c > hi) c = hi;
		d = (ch == 1) ? (hi - c) : (c - lo);
		return 15'((d * 32767) / span);
	endfunction

	// persistence timer: arm on condition, cancel when it goes away
	function automatic void arm_timer(int t, bit bad);
		if (bad && tmr_phase[t] == PH_IDLE) begin
			tmr_phase[t] = PH_RUN;
			tmr_count[t] = 0;
		end else if (!bad && tmr_phase[t] == PH_RUN) begin
			tmr_phase[t] = PH_IDLE;
			tmr_count[t] = 0;
		end
	endfunction

	function automatic void tick_timer(int t, int flt);
		if (tmr_phase[t] != PH_RUN) return;
		if (tmr_count[t] < CNT_MAX) tmr_count[t]++;
		if (tmr_count[t] >= int'(timeout_ticks)) begin
			faults[flt] = 1'b1;
			tmr_phase[t] = PH_EXP;
		end
	endfunction

	function automatic out_item_t monitor_step(in_item_t it);
		longint    raw [4];
		longint    na, da, nb, db, diff, pa;
		bit        ok;
		out_item_t r;
		if (it.req_type == REQ_SAMPLE) begin
			raw[0] = longint'($signed(it.pedal_a_word[14:3]));
			raw[1] = longint'($signed(it.pedal_b_word[14:3]));
			raw[2] = longint'($signed(it.front_brake_word[14:3]));
			raw[3] = longint'($signed(it.rear_brake_word[14:3]));
			for (int i = 0; i < 4; i++) scaled_q[i] = scale_ch(raw[i], i);
			pressed_q = raw[2] >= longint'(pressed_th);
			// pedal percents as exact fractions
			da = win_hi(0) - win_lo(0);
			na = raw[0] - win_lo(0);
			if (da <= 0) begin
				na = 0;
				da = 1;
			end
			db = win_hi(1) - win_lo(1);
			nb = win_hi(1) - raw[1];
			if (db <= 0) begin
				nb = 0;
				db = 1;
			end
			diff = labs(na * db - nb * da) * 100;
			arm_timer(0, diff >= 11 * da * db);
			// brake plus throttle, set then clear
			pa = labs(na) * 100;
			if (pressed_q && pa > 25 * da) faults[FLT_BT] = 1'b1;
			if (pa < 5 * da) faults[FLT_BT] = 1'b0;
			arm_timer(1, !it.brake_line_ok);
			ok = raw[0] >= short_th && raw[0] <= open_th &&
			     raw[1] >= short_th && raw[1] <= open_th;
			arm_timer(2, !ok);
		end else begin
			tick_timer(0, FLT_DISAGREE);
			tick_timer(1, FLT_LINE);
			tick_timer(2, FLT_RANGE);
		end
		r.pedal_a_scaled       = scaled_q[0];
		r.pedal_b_scaled       = scaled_q[1];
		r.brake_front_scaled   = scaled_q[2];
		r.brake_rear_scaled    = scaled_q[3];
		r.brake_is_pressed     = pressed_q;
		r.any_fault            = |faults;
		r.disagree_fault       = faults[FLT_DISAGREE];
		r.brake_throttle_fault = faults[FLT_BT];
		r.brake_line_fault     = faults[FLT_LINE];
		r.pedal_range_fault    = faults[FLT_RANGE];
		return r;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_q.size() == 0) begin
				$error("result item with nothing expected");
				fails++;
			end else begin
				e = exp_q.pop_front();
				if (out_data.pedal_a_scaled !== e.pedal_a_scaled) begin
					$error("pedal_a_scaled exp %0d got %0d", e.pedal_a_scaled,
						out_data.pedal_a_scaled);
					fails++;
				end
				if (out_data.pedal_b_scaled !== e.pedal_b_scaled) begin
					$error("pedal_b_scaled exp %0d got %0d", e.pedal_b_scaled,
						out_data.pedal_b_scaled);
					fails++;
				end
				if (out_data.brake_front_scaled !== e.brake_front_scaled) begin
					$error("brake_front_scaled exp %0d got %0d", e.brake_front_scaled,
						out_data.brake_front_scaled);
					fails++;
				end
				if (out_data.brake_rear_scaled !== e.brake_rear_scaled) begin
					$error("brake_rear_scaled exp %0d got %0d", e.brake_rear_scaled,
						out_data.brake_rear_scaled);
					fails++;
				end
				if (out_data.brake_is_pressed !== e.brake_is_pressed) begin
					$error("brake_is_pressed exp %0b got %0b", e.brake_is_pressed,
						out_data.brake_is_pressed);
					fails++;
				end
				if (out_data.any_fault !== e.any_fault) begin
					$error("any_fault exp %0b got %0b", e.any_fault, out_data.any_fault);
					fails++;
				end
				if (out_data.disagree_fault !== e.disagree_fault) begin
					$error("disagree_fault exp %0b got %0b", e.disagree_fault,
						out_data.disagree_fault);
					fails++;
				end
				if (out_data.brake_throttle_fault !== e.brake_throttle_fault) begin
					$error("brake_throttle_fault exp %0b got %0b", e.brake_throttle_fault,
						out_data.brake_throttle_fault);
					fails++;
				end
				if (out_data.brake_line_fault !== e.brake_line_fault) begin
					$error("brake_line_fault exp %0b got %0b", e.brake_line_fault,
						out_data.brake_line_fault);
					fails++;
				end
				if (out_data.pedal_range_fault !== e.pedal_range_fault) begin
					$error("pedal_range_fault exp %0b got %0b", e.pedal_range_fault,
						out_data.pedal_range_fault);
					fails++;
				end
			end
		end
		case (idle_mode)
			0: out_stall <= ($urandom_range(0, 99) < 75);
			1: out_stall <= ($urandom_range(0, 99) < 37);
			default: out_stall <= 1'b0;
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// hand one item over; valid stays up between back-to-back items
	task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_res);
		int pct;
		out_item_t r;
		pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 75 : 0;
		if ($urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = monitor_step(it);
		exp_q.push_back(fixed ? fixed_res : r);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_PRESSED_TH: pressed_th = val[11:0];
			REG_SHORT_TH:   short_th = val[11:0];
			REG_OPEN_TH:    open_th = val[11:0];
			REG_TIMEOUT:    timeout_ticks = val[15:0];
			default:        win_cfg[idx[1:0]] = val;
		endcase
	endtask

	function automatic logic [31:0] window(int lo, int hi);
		return {4'($urandom), 12'(hi), 4'($urandom), 12'(lo)};
	endfunction

	// block idle: no result owed and the pipeline drained
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(int p);
		int w [4][2];
		int th [4];
		case (p)
			0: begin
				w = '{'{100, 1900}, '{100, 1900}, '{0, 2047}, '{-500, 1500}};
				th = '{200, 50, 2000, 65535};
			end
			1: begin
				w = '{'{0, 2047}, '{0, 2047}, '{0, 1000}, '{0, 1000}};
				th = '{400, 20, 2040, 8};
			end
			2: begin
				// zero spans on pedal A and front brake
				w = '{'{500, 500}, '{0, 1000}, '{300, 300}, '{0, 4}};
				th = '{2047, 100, 1500, 3};
			end
			3: begin
				// every pedal sample fails the range check
				w = '{'{200, 1800}, '{300, 1700}, '{-100, 900}, '{10, 2000}};
				th = '{0, 2047, -2048, 2};
			end
			default: begin
				// full signed windows, rear inverted
				w = '{'{-2048, 2047}, '{-2048, 2047}, '{-2048, 2047}, '{2047, -2048}};
				th = '{-2048, -2048, 2047, 1};
			end
		endcase
		wait_idle();
		write_reg(REG_PEDAL_A_RANGE, window(w[0][0], w[0][1]));
		write_reg(REG_PEDAL_B_RANGE, window(w[1][0], w[1][1]));
		write_reg(REG_FRONT_BRAKE_RANGE, window(w[2][0], w[2][1]));
		write_reg(REG_REAR_BRAKE_RANGE, window(w[3][0], w[3][1]));
		write_reg(REG_PRESSED_TH, {20'($urandom), 12'(th[0])});
		write_reg(REG_SHORT_TH, {20'($urandom), 12'(th[1])});
		write_reg(REG_OPEN_TH, {20'($urandom), 12'(th[2])});
		write_reg(REG_TIMEOUT, {16'($urandom), 16'(th[3])});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pack_word(longint raw);
		return {1'($urandom), 12'(raw), 3'($urandom)};
	endfunction

	// random item: mostly plausible pedal pairs under a slowly changing regime
	function automatic in_item_t random_item(int regime);
		in_item_t it;
		longint lo, hi, pos, ra, rb, rf;
		it = '0;
		if ($urandom_range(0, 99) < 25) begin
			it = IN_W'({$urandom, $urandom, $urandom});
			it.req_type = REQ_TICK;
			return it;
		end
		if ($urandom_range(0, 9) == 0) begin
			it = IN_W'({$urandom, $urandom, $urandom});
			it.req_type = REQ_SAMPLE;
			return it;
		end
		pos = $urandom_range(0, 100);
		lo = win_lo(0);
		hi = win_hi(0);
		ra = (hi > lo) ? lo + (hi - lo) * pos / 100 : longint'($urandom_range(0, 2047));
		lo = win_lo(1);
		hi = win_hi(1);
		rb = (hi > lo) ? hi - (hi - lo) * pos / 100 : longint'($urandom_range(0, 2047));
		rb += $urandom_range(0, 20) - 10;
		if (regime == 1) rb += (($urandom_range(0, 1) != 0) ? 400 : -400);
		if (regime == 3) ra = longint'($signed(12'($urandom)));
		rf = longint'(pressed_th) + $urandom_range(0, 60) - 30;
		if ($urandom_range(0, 3) == 0) rf = longint'($signed(12'($urandom)));
		it.req_type = REQ_SAMPLE;
		it.pedal_a_word = pack_word(ra);
		it.pedal_b_word = pack_word(rb);
		it.front_brake_word = pack_word(rf);
		it.rear_brake_word = 16'($urandom);
		it.brake_line_ok = (regime == 2) ? 1'b0 : ($urandom_range(0, 49) != 0);
		return it;
	endfunction

	typedef struct {
		in_item_t  it;
		bit        fixed;
		out_item_t res;
	} stim_row_t;

	function automatic in_item_t mk(logic t, logic [15:0] a, logic [15:0] b,
			logic [15:0] f, logic [15:0] r, logic ok);
		in_item_t it;
		it.req_type = t;
		it.pedal_a_word = a;
		it.pedal_b_word = b;
		it.front_brake_word = f;
		it.rear_brake_word = r;
		it.brake_line_ok = ok;
		return it;
	endfunction

	initial begin
		stim_row_t rows [NUM_DIRECTED];
		int regime;
		for (int i = 0; i < 4; i++) begin
			win_cfg[i] = RANGE_RESET;
			scaled_q[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			tmr_phase[i] = PH_IDLE;
			tmr_count[i] = 0;
		end
		pressed_th = PRESSED_TH_RESET;
		short_th = SHORT_TH_RESET;
		open_th = OPEN_TH_RESET;
		timeout_ticks = TIMEOUT_RESET;
		pressed_q = 1'b0;
		faults = '0;

		// directed table; raw 2047 is 0x3FF8, raw -2048 is 0x4000
		rows[0]  = '{mk(REQ_TICK, 0, 0, 0, 0, 1), 1'b1, '0};
		rows[1]  = '{mk(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1), 0, '0};
		rows[2]  = '{mk(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1), 0, '0};
		rows[3]  = '{mk(REQ_SAMPLE, 16'h7FF8, 16'h7FF8, 16'h7FF8, 16'h7FF8, 1), 0, '0};
		rows[4]  = '{mk(REQ_SAMPLE, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 0), 0, '0};
		rows[5]  = '{mk(REQ_SAMPLE, 16'hC007, 16'h8007, 16'hBFFF, 16'h3FFF, 1), 0, '0};
		rows[6]  = '{mk(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 0, '0};
		// pedals agree at half travel, brake off
		rows[7]  = '{mk(REQ_SAMPLE, 16'h2000, 16'h1FF8, 16'h0000, 16'h1000, 1), 0, '0};
		// brake pressed with open throttle
		rows[8]  = '{mk(REQ_SAMPLE, 16'h2000, 16'h1FF8, 16'h0640, 16'h1000, 1), 0, '0};
		// throttle between clear and set levels keeps the latch
		rows[9]  = '{mk(REQ_SAMPLE, 16'h0500, 16'h3A80, 16'h0000, 16'h0000, 1), 0, '0};
		// throttle closed clears it
		rows[10] = '{mk(REQ_SAMPLE, 16'h0190, 16'h3E60, 16'h0640, 16'h0000, 1), 0, '0};
		// pedals disagree
		rows[11] = '{mk(REQ_SAMPLE, 16'h3000, 16'h3000, 16'h0000, 16'h0000, 1), 0, '0};
		rows[12] = '{mk(REQ_TICK, 0, 0, 0, 0, 1), 0, '0};
		rows[13] = '{mk(REQ_TICK, 0, 0, 0, 0, 1), 0, '0};
		// pedal shorted and open
		rows[14] = '{mk(REQ_SAMPLE, 16'h0008, 16'h3F80, 16'h0000, 16'h0000, 0), 0, '0};
		rows[15] = '{mk(REQ_TICK, 0, 0, 0, 0, 1), 0, '0};
		rows[16] = '{mk(REQ_SAMPLE, 16'h3F00, 16'h3F00, 16'h0000, 16'h0000, 1), 0, '0};
		// condition gone cancels the timers
		rows[17] = '{mk(REQ_SAMPLE, 16'h2000, 16'h1FF8, 16'h0000, 16'h0000, 1), 0, '0};
		rows[18] = '{mk(REQ_TICK, 0, 0, 0, 0, 1), 0, '0};
		rows[19] = '{mk(REQ_SAMPLE, 16'h7FF8, 16'h4000, 16'h7FF8, 16'h4000, 1), 0, '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_mode = 0;
		foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].res);

		// random part: one setting per slice, idling pattern by progress
		regime = 0;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n % (NUM_RANDOM / 5) == 0 && n / (NUM_RANDOM / 5) < 5)
				load_setting(n / (NUM_RANDOM / 5));
			idle_mode = (n < NUM_RANDOM / 3) ? 0 : (n < 2 * NUM_RANDOM / 3) ? 1 : 2;
			if ($urandom_range(0, 29) == 0) regime = $urandom_range(0, 3);
			send_item(random_item(regime), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
